FILE: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants for the stable sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int PRIO_WIDTH      = 32;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        FAULT_OK        = 2'd0,
        FAULT_OVERFLOW  = 2'd1,
        FAULT_UNDERFLOW = 2'd2
    } t_fault;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cmd;

endpackage

FILE: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain; shifts right on insert, left on remove
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spq_pkg::t_cmd                 i_cmd,
    input  logic [VALUE_WIDTH-1:0]        i_new_value,
    input  logic [spq_pkg::PRIO_WIDTH-1:0] i_new_prio,
    input  logic                          i_left_move,
    input  logic                          i_left_valid,
    input  logic [VALUE_WIDTH-1:0]        i_left_value,
    input  logic [spq_pkg::PRIO_WIDTH-1:0] i_left_prio,
    input  logic                          i_right_valid,
    input  logic [VALUE_WIDTH-1:0]        i_right_value,
    input  logic [spq_pkg::PRIO_WIDTH-1:0] i_right_prio,
    output logic                          o_move,
    output logic                          o_valid,
    output logic [VALUE_WIDTH-1:0]        o_value,
    output logic [spq_pkg::PRIO_WIDTH-1:0] o_prio
);
    import spq_pkg::*;

    logic                   r_valid;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [PRIO_WIDTH-1:0]  r_prio;
    logic                   n_valid;
    logic [VALUE_WIDTH-1:0] n_value;
    logic [PRIO_WIDTH-1:0]  n_prio;

    // strictly larger priority moves back, so equal priorities stay ahead
    assign o_move = !r_valid || (r_prio > i_new_prio);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_prio  = r_prio;
        if (i_cmd.enq && o_move) begin
            if (i_left_move) begin
                n_valid = i_left_valid;
                n_value = i_left_value;
                n_prio  = i_left_prio;
            end else begin
                n_valid = 1'b1;
                n_value = i_new_value;
                n_prio  = i_new_prio;
            end
        end else if (i_cmd.deq) begin
            n_valid = i_right_valid;
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_prio  = r_prio;

endmodule

FILE: sv/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// minimum-first priority queue with first-in first-out order on equal keys
// ----------------------------------------------------------------------------
// The queue is a row of DEPTH cells kept sorted by ascending priority; every
// cell compares the incoming priority against its own in parallel, so busy
// never rises: a command may be started in every cycle. The result word
// (head, count, empty flag, fault) appears with o_done in the cycle right
// after the command is taken and must be captured then, since the receiver
// cannot stall it. Inserting into a full queue or removing from an empty
// one changes nothing and reports a fault. There is no initialization
// sweep after reset.
module stable_sorted_priority_queue #(
    parameter int DEPTH       = spq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_operation,
    input  logic [VALUE_WIDTH-1:0]           i_item_value,
    input  logic [spq_pkg::PRIO_WIDTH-1:0]    i_item_priority,
    output logic                             o_done,
    output logic [VALUE_WIDTH-1:0]           o_head_value,
    output logic [spq_pkg::PRIO_WIDTH-1:0]    o_head_priority,
    output logic [$clog2(DEPTH+1)-1:0]       o_entry_count,
    output logic                             o_is_empty,
    output logic [1:0]                       o_fault
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic                   w_move  [DEPTH];
    logic                   w_valid [DEPTH];
    logic [VALUE_WIDTH-1:0] w_value [DEPTH];
    logic [PRIO_WIDTH-1:0]  w_prio  [DEPTH];

    logic    w_accept;
    logic    w_full;
    logic    w_empty;
    t_cmd    w_cmd;
    t_fault  n_fault;

    logic    [CW-1:0] r_count;
    logic    [CW-1:0] n_count;
    t_fault  r_fault;
    logic    r_done;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = w_valid[DEPTH-1];
    assign w_empty  = !w_valid[0];

    always_comb begin
        w_cmd   = '0;
        n_fault = FAULT_OK;
        n_count = r_count;
        if (w_accept) begin
            if (t_op'(i_operation) == OP_ENQUEUE) begin
                if (w_full) begin
                    n_fault = FAULT_OVERFLOW;
                end else begin
                    w_cmd.enq = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end else begin
                if (w_empty) begin
                    n_fault = FAULT_UNDERFLOW;
                end else begin
                    w_cmd.deq = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                   w_lmove;
        logic                   w_lvalid;
        logic [VALUE_WIDTH-1:0] w_lvalue;
        logic [PRIO_WIDTH-1:0]  w_lprio;
        logic                   w_rvalid;
        logic [VALUE_WIDTH-1:0] w_rvalue;
        logic [PRIO_WIDTH-1:0]  w_rprio;

        if (g == 0) begin : g_first
            assign w_lmove  = 1'b0;
            assign w_lvalid = 1'b0;
            assign w_lvalue = '0;
            assign w_lprio  = '0;
        end else begin : g_mid_l
            assign w_lmove  = w_move[g-1];
            assign w_lvalid = w_valid[g-1];
            assign w_lvalue = w_value[g-1];
            assign w_lprio  = w_prio[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_rvalid = 1'b0;
            assign w_rvalue = '0;
            assign w_rprio  = '0;
        end else begin : g_mid_r
            assign w_rvalid = w_valid[g+1];
            assign w_rvalue = w_value[g+1];
            assign w_rprio  = w_prio[g+1];
        end

        spq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_new_value   (i_item_value),
            .i_new_prio    (i_item_priority),
            .i_left_move   (w_lmove),
            .i_left_valid  (w_lvalid),
            .i_left_value  (w_lvalue),
            .i_left_prio   (w_lprio),
            .i_right_valid (w_rvalid),
            .i_right_value (w_rvalue),
            .i_right_prio  (w_rprio),
            .o_move        (w_move[g]),
            .o_valid       (w_valid[g]),
            .o_value       (w_value[g]),
            .o_prio        (w_prio[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fault <= FAULT_OK;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= w_accept;
            if (w_accept) begin
                r_fault <= n_fault;
            end
        end
    end

    // head fields read straight from cell zero, which holds the post-step state
    assign o_done          = r_done;
    assign o_head_value    = w_valid[0] ? w_value[0] : '0;
    assign o_head_priority = w_valid[0] ? w_prio[0] : '0;
    assign o_entry_count   = r_count;
    assign o_is_empty      = w_empty;
    assign o_fault         = r_fault;

endmodule

FILE: sim/tb_stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_stable_sorted_priority_queue
// self-checking bench for the stable sorted priority queue
// ----------------------------------------------------------------------------
// A driver feeds enqueue and dequeue words from a backlog with random gaps.
// A monitor keeps its own sorted copy of the queue, predicts the head report
// for every accepted word and compares it with the report that follows.
// Directed words cover empty removal, extreme keys and values and ties.
// Random phases then lean toward filling, draining or mixing, so both the
// full and the empty limits are hit many times.
// ----------------------------------------------------------------------------
module tb_stable_sorted_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int VALUE_WIDTH    = VALUE_WIDTH_DEF;
    localparam int CNT_WIDTH      = $clog2(DEPTH + 1);
    localparam int RANDOM_WORDS   = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTED   = 10;

    typedef struct {
        t_op                   op;
        logic [VALUE_WIDTH-1:0] value;
        logic [PRIO_WIDTH-1:0]  prio;
    } t_queue_cmd;

    typedef struct {
        logic [VALUE_WIDTH-1:0] head_value;
        logic [PRIO_WIDTH-1:0]  head_prio;
        logic [CNT_WIDTH-1:0]   count;
        logic                   empty;
        t_fault                 fault;
    } t_head_report;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   i_operation = 1'b0;
    logic [VALUE_WIDTH-1:0] i_item_value = '0;
    logic [PRIO_WIDTH-1:0]  i_item_priority = '0;
    logic                   o_done;
    logic [VALUE_WIDTH-1:0] o_head_value;
    logic [PRIO_WIDTH-1:0]  o_head_priority;
    logic [CNT_WIDTH-1:0]   o_entry_count;
    logic                   o_is_empty;
    logic [1:0]             o_fault;

    t_queue_cmd   cmd_backlog[$];
    t_head_report head_reports[$];
    t_queue_cmd   drive_cmd;
    int           gap_left = 0;
    int           idle_cycles = 0;
    int           fail_count = 0;

    // shadow copy of the sorted store
    logic [VALUE_WIDTH-1:0] shadow_value[DEPTH];
    logic [PRIO_WIDTH-1:0]  shadow_prio[DEPTH];
    int                     shadow_count = 0;

    stable_sorted_priority_queue #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_done          (o_done),
        .o_head_value    (o_head_value),
        .o_head_priority (o_head_priority),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty),
        .o_fault         (o_fault)
    );

    always #10 i_clk = ~i_clk;

    // applies one word to the shadow store and returns the head report
    function automatic t_head_report step_shadow(t_op op, logic [VALUE_WIDTH-1:0] value,
                                                 logic [PRIO_WIDTH-1:0] prio);
        t_head_report rep;
        int           pos;
        int           i;
        rep.fault = FAULT_OK;
        if (op == OP_ENQUEUE) begin
            if (shadow_count >= DEPTH) begin
                rep.fault = FAULT_OVERFLOW;
            end else begin
                // new entry goes behind every key less than or equal to its own
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
                for (i = shadow_count; i > pos; i--) begin
                    shadow_value[i] = shadow_value[i-1];
                    shadow_prio[i]  = shadow_prio[i-1];
                end
                shadow_value[pos] = value;
                shadow_prio[pos]  = prio;
                shadow_count++;
            end
        end else if (shadow_count == 0) begin
            rep.fault = FAULT_UNDERFLOW;
        end else begin
            for (i = 0; i + 1 < shadow_count; i++) begin
                shadow_value[i] = shadow_value[i+1];
                shadow_prio[i]  = shadow_prio[i+1];
            end
            shadow_count--;
        end
        if (shadow_count > 0) begin
            rep.head_value = shadow_value[0];
            rep.head_prio  = shadow_prio[0];
        end else begin
            rep.head_value = '0;
            rep.head_prio  = '0;
        end
        rep.count = CNT_WIDTH'(shadow_count);
        rep.empty = (shadow_count == 0);
        return rep;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 87) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // keys from a narrow set often, so ties are common
    function automatic logic [PRIO_WIDTH-1:0] pick_prio();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35) return PRIO_WIDTH'($urandom_range(3));
        if (roll < 45) return $urandom_range(1) ? '1 : '0;
        if (roll < 55) return '1 - PRIO_WIDTH'($urandom_range(2));
        return $urandom;
    endfunction

    task automatic add_cmd(t_op op, logic [VALUE_WIDTH-1:0] value,
                           logic [PRIO_WIDTH-1:0] prio);
        t_queue_cmd c;
        c.op    = op;
        c.value = value;
        c.prio  = prio;
        cmd_backlog.push_back(c);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else if (!start || !busy) begin
            if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cmd_backlog.size() > 0) begin
                drive_cmd = cmd_backlog.pop_front();
                i_operation     <= drive_cmd.op;
                i_item_value    <= drive_cmd.value;
                i_item_priority <= drive_cmd.prio;
                start           <= 1'b1;
                gap_left        <= pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        t_head_report want;
        if (i_rst_n) begin
            if (o_done) begin
                if (head_reports.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTED)
                        $display("unexpected result word: head %h/%h count %0d empty %b fault %0d",
                                 o_head_value, o_head_priority, o_entry_count, o_is_empty,
                                 o_fault);
                end else begin
                    want = head_reports.pop_front();
                    if (o_head_value !== want.head_value || o_head_priority !== want.head_prio ||
                        o_entry_count !== want.count || o_is_empty !== want.empty ||
                        o_fault !== want.fault) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTED) begin
                            $write("mismatch at %0t: head %h/%h count %0d empty %b fault %0d,",
                                   $realtime, o_head_value, o_head_priority, o_entry_count,
                                   o_is_empty, o_fault);
                            $display(" expected %h/%h count %0d empty %b fault %0d",
                                     want.head_value, want.head_prio, want.count, want.empty,
                                     want.fault);
                        end
                    end
                end
            end
            if (start && !busy)
                head_reports.push_back(step_shadow(t_op'(i_operation), i_item_value,
                                                   i_item_priority));
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        int   words;
        int   seg_len;
        int   enq_pct;
        int   k;
        t_op  op;

        // directed part
        add_cmd(OP_DEQUEUE, '1, '1);                  // removal from empty
        add_cmd(OP_ENQUEUE, '0, '1);
        add_cmd(OP_ENQUEUE, '1, '0);                  // new head at lowest key
        add_cmd(OP_ENQUEUE, 32'h0000_00a1, 32'd5);
        add_cmd(OP_ENQUEUE, 32'h0000_00b2, 32'd5);    // ties keep arrival order
        add_cmd(OP_ENQUEUE, 32'h0000_00c3, 32'd5);
        add_cmd(OP_ENQUEUE, 32'h5555_5555, 32'd4);
        add_cmd(OP_ENQUEUE, 32'haaaa_aaaa, 32'd6);
        add_cmd(OP_ENQUEUE, 32'h0000_0001, '1);       // tie at highest key
        add_cmd(OP_ENQUEUE, 32'h0000_0002, '0);       // tie at lowest key
        for (k = 0; k < 10; k++) add_cmd(OP_DEQUEUE, $urandom, $urandom);
        add_cmd(OP_DEQUEUE, '0, '0);                  // empty again

        // random phases leaning toward fill, drain or a mix
        words = 0;
        while (words < RANDOM_WORDS) begin
            seg_len = $urandom_range(40, 10);
            case ($urandom_range(2))
                0: enq_pct = 85;
                1: enq_pct = 15;
                default: enq_pct = 50;
            endcase
            for (k = 0; k < seg_len; k++) begin
                op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
                add_cmd(op, $urandom, pick_prio());
            end
            words += seg_len;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (cmd_backlog.size() > 0 || start);
        do @(posedge i_clk); while (head_reports.size() > 0);
        repeat (5) @(posedge i_clk);

        if (fail_count == 0 && head_reports.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_sorted_priority_queue.sv
sim/tb_stable_sorted_priority_queue.sv
